[hdl/assert_macros.svh]
// Assertion macros for the rational unit modules; included by rau_ctrl.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Implication checked even during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`endif

[hdl/rau_pkg.sv]
// Shared types and constants for the rational arithmetic unit.
// No dependencies.
package rau_pkg;
    localparam int unsigned WORD_BITS_DEF = 64;
    localparam int unsigned FIELD_BITS = 64;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    typedef struct packed {
        logic [1:0]            operation;
        logic [FIELD_BITS-1:0] lhs_num;
        logic [FIELD_BITS-1:0] lhs_den;
        logic                  lhs_neg;
        logic [FIELD_BITS-1:0] rhs_num;
        logic [FIELD_BITS-1:0] rhs_den;
        logic                  rhs_neg;
    } req_t;

    typedef struct packed {
        logic [FIELD_BITS-1:0] res_num;
        logic [FIELD_BITS-1:0] res_den;
        logic                  res_neg;
        logic                  overflow;
    } rsp_t;

    // Datapath micro-operations issued by the controller.
    // Each multiply command is held until all four of its partial products are summed.
    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,      // capture operands, apply subtract/divide swaps
        DP_MUL_A,     // t1 = ln*rd  (or ln*rn for mul/div)
        DP_MUL_B,     // t2 = ld*rn
        DP_MUL_C,     // den = ld*rd
        DP_COMBINE,   // form numerator and sign
        DP_GCD_INIT,  // x=num, y=den
        DP_DIV_INIT,  // start x % y
        DP_DIV_STEP,  // one restoring step
        DP_GCD_SWAP,  // x=y, y=rem
        DP_RED_INIT,  // start num / g
        DP_RED_NUM,   // store quotient in num, start den / g
        DP_RED_DEN    // store quotient in den
    } dp_cmd_t;

    typedef struct packed {
        logic y_zero;    // gcd divisor is zero
        logic div_last;  // current division step is last
        logic g_gt1;     // gcd result above one
        logic mul_mode;  // multiply/divide op
        logic mul_last;  // last partial product of a multiply
    } dp_status_t;
endpackage

[hdl/rau_datapath.sv]
// Datapath: operand regs, one shared multiplier, shared restoring divider.
// Depends on rau_pkg.
module rau_datapath #(
    parameter int unsigned WORD_BITS = rau_pkg::WORD_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  rau_pkg::dp_cmd_t    cmd,
    input  rau_pkg::req_t       req,
    output rau_pkg::dp_status_t status,
    output rau_pkg::rsp_t       rsp
);
    localparam int unsigned CW = $clog2(WORD_BITS);
    localparam int unsigned HB = (WORD_BITS + 1) / 2;
    localparam int unsigned PW = 2 * WORD_BITS;

    logic [WORD_BITS-1:0] ln_reg, ld_reg, rn_reg, rd_reg;
    logic                 ls_reg, rs_reg, mulop_reg;
    logic [WORD_BITS-1:0] t1_reg, t2_reg, num_reg, den_reg;
    logic                 neg_reg, ovf_reg;
    logic [WORD_BITS-1:0] x_reg, y_reg;
    logic [WORD_BITS-1:0] q_reg, r_reg, dvd_reg, dvs_reg;
    logic [CW-1:0]        cnt_reg;
    logic [1:0]           mcnt_reg;
    logic [PW-1:0]        acc_reg;

    logic [1:0]           op;
    logic [WORD_BITS-1:0] ma, mb;
    logic [HB-1:0]        pa, pb;
    logic [2*HB-1:0]      pp;
    logic [PW-1:0]        pp_sh;
    logic [PW-1:0]        acc_sum;
    logic                 mul_cmd;
    logic                 mul_last;
    logic                 movf;
    logic [WORD_BITS:0]   sum;
    logic [WORD_BITS:0]   rsh;
    logic [WORD_BITS:0]   rsub;

    assign op = req.operation;

    always_comb
    begin
        ma = ln_reg;
        mb = rd_reg;
        case (cmd)
            rau_pkg::DP_MUL_A:
            begin
                ma = ln_reg;
                mb = mulop_reg ? rn_reg : rd_reg;
            end
            rau_pkg::DP_MUL_B:
            begin
                ma = ld_reg;
                mb = rn_reg;
            end
            default:
            begin
                ma = ld_reg;
                mb = rd_reg;
            end
        endcase
    end

    // Half-word partial products in order lo*lo, hi*lo, lo*hi, hi*hi.
    assign mul_cmd  = (cmd == rau_pkg::DP_MUL_A) || (cmd == rau_pkg::DP_MUL_B) ||
                      (cmd == rau_pkg::DP_MUL_C);
    assign mul_last = (mcnt_reg == 2'd3);
    assign pa = mcnt_reg[0] ? HB'(ma >> HB) : ma[HB-1:0];
    assign pb = mcnt_reg[1] ? HB'(mb >> HB) : mb[HB-1:0];
    assign pp = pa * pb;
    assign pp_sh = (mcnt_reg == 2'd3) ? (PW'(pp) << (2 * HB)) :
                   (mcnt_reg == 2'd0) ? PW'(pp) : (PW'(pp) << HB);
    assign acc_sum = ((mcnt_reg == 2'd0) ? PW'(0) : acc_reg) + pp_sh;
    assign movf = |acc_sum[PW-1:WORD_BITS];

    assign sum  = {1'b0, t1_reg} + {1'b0, t2_reg};
    assign rsh  = {r_reg, dvd_reg[WORD_BITS-1]};
    assign rsub = rsh - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            mcnt_reg <= '0;
            acc_reg  <= '0;
        end
        else
        begin
            if (cmd == rau_pkg::DP_DIV_INIT || cmd == rau_pkg::DP_RED_INIT ||
                cmd == rau_pkg::DP_RED_NUM)
                cnt_reg <= '0;
            else if (cmd == rau_pkg::DP_DIV_STEP)
                cnt_reg <= cnt_reg + CW'(1);
            if (mul_cmd)
            begin
                mcnt_reg <= mcnt_reg + 2'd1;
                acc_reg  <= acc_sum;
            end
            else if (cmd == rau_pkg::DP_LOAD)
                mcnt_reg <= '0;
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd)
            rau_pkg::DP_LOAD:
            begin
                ln_reg    <= req.lhs_num[WORD_BITS-1:0];
                ld_reg    <= req.lhs_den[WORD_BITS-1:0];
                ls_reg    <= req.lhs_neg;
                mulop_reg <= op[1];
                ovf_reg   <= 1'b0;
                if (op == rau_pkg::OP_DIV)
                begin
                    rn_reg <= req.rhs_den[WORD_BITS-1:0];
                    rd_reg <= req.rhs_num[WORD_BITS-1:0];
                end
                else
                begin
                    rn_reg <= req.rhs_num[WORD_BITS-1:0];
                    rd_reg <= req.rhs_den[WORD_BITS-1:0];
                end
                rs_reg <= (op == rau_pkg::OP_SUB) ? ~req.rhs_neg : req.rhs_neg;
            end
            rau_pkg::DP_MUL_A:
            begin
                if (mul_last)
                begin
                    t1_reg  <= acc_sum[WORD_BITS-1:0];
                    ovf_reg <= ovf_reg | movf;
                end
            end
            rau_pkg::DP_MUL_B:
            begin
                if (mul_last)
                begin
                    t2_reg  <= acc_sum[WORD_BITS-1:0];
                    ovf_reg <= ovf_reg | movf;
                end
            end
            rau_pkg::DP_MUL_C:
            begin
                if (mul_last)
                begin
                    den_reg <= acc_sum[WORD_BITS-1:0];
                    ovf_reg <= ovf_reg | movf;
                end
            end
            rau_pkg::DP_COMBINE:
            begin
                if (mulop_reg)
                begin
                    num_reg <= t1_reg;
                    neg_reg <= ls_reg ^ rs_reg;
                end
                else if (ls_reg == rs_reg)
                begin
                    num_reg <= sum[WORD_BITS-1:0];
                    neg_reg <= ls_reg;
                    ovf_reg <= ovf_reg | sum[WORD_BITS];
                end
                else if (t1_reg > t2_reg)
                begin
                    num_reg <= t1_reg - t2_reg;
                    neg_reg <= ls_reg;
                end
                else
                begin
                    num_reg <= t2_reg - t1_reg;
                    neg_reg <= (t2_reg > t1_reg) ? rs_reg : 1'b0;
                end
            end
            rau_pkg::DP_GCD_INIT:
            begin
                x_reg <= num_reg;
                y_reg <= den_reg;
            end
            rau_pkg::DP_DIV_INIT:
            begin
                dvd_reg <= x_reg;
                dvs_reg <= y_reg;
                r_reg   <= '0;
            end
            rau_pkg::DP_RED_INIT:
            begin
                dvd_reg <= num_reg;
                dvs_reg <= x_reg;
                r_reg   <= '0;
            end
            rau_pkg::DP_RED_NUM:
            begin
                num_reg <= q_reg;
                dvd_reg <= den_reg;
                r_reg   <= '0;
            end
            rau_pkg::DP_RED_DEN:
            begin
                den_reg <= q_reg;
            end
            rau_pkg::DP_DIV_STEP:
            begin
                dvd_reg <= {dvd_reg[WORD_BITS-2:0], 1'b0};
                if (!rsub[WORD_BITS])
                begin
                    r_reg <= rsub[WORD_BITS-1:0];
                    q_reg <= {q_reg[WORD_BITS-2:0], 1'b1};
                end
                else
                begin
                    r_reg <= rsh[WORD_BITS-1:0];
                    q_reg <= {q_reg[WORD_BITS-2:0], 1'b0};
                end
            end
            rau_pkg::DP_GCD_SWAP:
            begin
                x_reg <= y_reg;
                y_reg <= r_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign status.y_zero   = (y_reg == '0);
    assign status.div_last = (cnt_reg == CW'(WORD_BITS - 1));
    assign status.g_gt1    = (x_reg > WORD_BITS'(1));
    assign status.mul_mode = mulop_reg;
    assign status.mul_last = mul_last;

    always_comb
    begin
        rsp.res_num  = rau_pkg::FIELD_BITS'(num_reg);
        rsp.res_den  = rau_pkg::FIELD_BITS'(den_reg);
        rsp.res_neg  = neg_reg & (num_reg != '0);
        rsp.overflow = ovf_reg;
    end
endmodule

[hdl/rau_ctrl.sv]
// Controller FSM sequencing multiplies, Euclid loop and reduction.
// Depends on rau_pkg and assert_macros.svh.
`include "assert_macros.svh"
module rau_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  rau_pkg::dp_status_t status,
    output rau_pkg::dp_cmd_t    cmd,
    output logic                busy,
    output logic                done
);
    typedef enum logic [3:0] {
        S_IDLE, S_MUL_A, S_MUL_B, S_MUL_C, S_COMB, S_GCD_INIT, S_GCD_TEST,
        S_MOD, S_SWAP, S_RED_CHK, S_RED_NUM, S_RED_NUMEND, S_RED_DEN,
        S_RED_DENEND, S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   done_reg, done_next;

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        cmd        = rau_pkg::DP_NOP;
        unique case (state_reg)
            S_IDLE:
                if (start)
                begin
                    cmd = rau_pkg::DP_LOAD;
                    state_next = S_MUL_A;
                end
            S_MUL_A:
            begin
                cmd = rau_pkg::DP_MUL_A;
                if (status.mul_last)
                    state_next = status.mul_mode ? S_MUL_C : S_MUL_B;
            end
            S_MUL_B:
            begin
                cmd = rau_pkg::DP_MUL_B;
                if (status.mul_last)
                    state_next = S_MUL_C;
            end
            S_MUL_C:
            begin
                cmd = rau_pkg::DP_MUL_C;
                if (status.mul_last)
                    state_next = S_COMB;
            end
            S_COMB:
            begin
                cmd = rau_pkg::DP_COMBINE;
                state_next = S_GCD_INIT;
            end
            S_GCD_INIT:
            begin
                cmd = rau_pkg::DP_GCD_INIT;
                state_next = S_GCD_TEST;
            end
            S_GCD_TEST:
                if (status.y_zero)
                    state_next = S_RED_CHK;
                else
                begin
                    cmd = rau_pkg::DP_DIV_INIT;
                    state_next = S_MOD;
                end
            S_MOD:
            begin
                cmd = rau_pkg::DP_DIV_STEP;
                if (status.div_last)
                    state_next = S_SWAP;
            end
            S_SWAP:
            begin
                cmd = rau_pkg::DP_GCD_SWAP;
                state_next = S_GCD_TEST;
            end
            S_RED_CHK:
                if (status.g_gt1)
                begin
                    cmd = rau_pkg::DP_RED_INIT;
                    state_next = S_RED_NUM;
                end
                else
                    state_next = S_DONE;
            S_RED_NUM:
            begin
                cmd = rau_pkg::DP_DIV_STEP;
                if (status.div_last)
                    state_next = S_RED_NUMEND;
            end
            S_RED_NUMEND:
            begin
                cmd = rau_pkg::DP_RED_NUM;
                state_next = S_RED_DEN;
            end
            S_RED_DEN:
            begin
                cmd = rau_pkg::DP_DIV_STEP;
                if (status.div_last)
                    state_next = S_RED_DENEND;
            end
            S_RED_DENEND:
            begin
                cmd = rau_pkg::DP_RED_DEN;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                done_next = 1'b1;
                state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

    `ASSERT_CLK(a_done_pulse, clk, rst_n, done |=> !done, "done longer than one cycle")
    `ASSERT_CLK(a_done_idle, clk, rst_n, done |-> state_reg == S_IDLE,
                "done outside idle")
    `ASSERT_CLK(a_start_leaves, clk, rst_n, (start && !busy) |=> busy,
                "accepted item did not start work")
endmodule

[hdl/rational_arith_unit.sv]
// Top level of the rational arithmetic unit.
// Depends on rau_pkg, rau_ctrl and rau_datapath.
//
// Computes one reduced sign-magnitude fraction per item: add, subtract,
// multiply or divide of two fractions, then division of numerator and
// denominator by their Euclid GCD when it exceeds one. An item is taken
// when start is high and busy is low; the result shows on rsp for exactly
// one cycle with done high, and the receiver cannot stall it. The rsp
// value holds until the next item is taken. Each product is summed from
// four half-word partial products, one per cycle; add/subtract forms
// three products and multiply/divide two. Then come the combine and GCD
// setup steps, then per Euclid iteration a test, a bit-serial restoring
// division for the remainder and a swap, then one final test, then the
// reduction (numerator and denominator each divided by the GCD; a single
// check when the GCD is 0 or 1), a finish step and the done cycle. At
// WORD_BITS=64 Euclid needs at most about 92 rounds, and the shared
// divider dominates the run time. No new item is taken while busy.
// Overflow reports any product or sum that wrapped past WORD_BITS
// bits.
module rational_arith_unit #(
    parameter int unsigned WORD_BITS = rau_pkg::WORD_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  rau_pkg::req_t req,
    output logic          done,
    output rau_pkg::rsp_t rsp
);
    rau_pkg::dp_cmd_t    cmd;
    rau_pkg::dp_status_t status;

    rau_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    rau_datapath #(
        .WORD_BITS (WORD_BITS)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .req    (req),
        .status (status),
        .rsp    (rsp)
    );
endmodule

[dv/tb_top.sv]
// Self-checking testbench for rational_arith_unit: directed and random items.
// Depends on rau_pkg and the rational_arith_unit RTL.
module tb_top;
    localparam int unsigned WB = rau_pkg::WORD_BITS_DEF;
    localparam int WATCHDOG_LIMIT = 40000;

    // Expected-result store plus the checker that compares against it.
    class frac_scoreboard;
        rau_pkg::rsp_t pending[$];
        int errors;

        function void note_item(rau_pkg::rsp_t r);
            pending.push_back(r);
        endfunction

        function void check_result(rau_pkg::rsp_t got);
            rau_pkg::rsp_t exp_r;
            if (pending.size() == 0)
            begin
                $error("result with no item pending");
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            if (got.res_num !== exp_r.res_num)
            begin
                $error("res_num exp %0d got %0d", exp_r.res_num, got.res_num);
                errors++;
            end
            if (got.res_den !== exp_r.res_den)
            begin
                $error("res_den exp %0d got %0d", exp_r.res_den, got.res_den);
                errors++;
            end
            if (got.res_neg !== exp_r.res_neg)
            begin
                $error("res_neg exp %0d got %0d", exp_r.res_neg, got.res_neg);
                errors++;
            end
            if (got.overflow !== exp_r.overflow)
            begin
                $error("overflow exp %0d got %0d", exp_r.overflow, got.overflow);
                errors++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic done;
    rau_pkg::req_t req = '0;
    rau_pkg::rsp_t rsp;

    frac_scoreboard sb = new();
    int idle_cycles = 0;
    bit timed_out = 1'b0;

    rational_arith_unit u_top (.clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
                               .req(req), .done(done), .rsp(rsp));

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Wrapping multiply at word width; flags a wrap.
    function automatic logic [WB-1:0] wrap_mul(logic [WB-1:0] a, logic [WB-1:0] b,
                                               inout bit ovf);
        logic [2*WB-1:0] p;
        p = a * b;
        if (p[2*WB-1:WB] != '0)
            ovf = 1'b1;
        return p[WB-1:0];
    endfunction

    // Computes the reduced fraction an item should produce.
    function automatic rau_pkg::rsp_t reduced_fraction(rau_pkg::req_t r);
        logic [WB-1:0] ln, ld, rn, rd, t1, t2, num, den, x, y, tmp;
        logic [WB:0] sum;
        bit ls, rs, neg, ovf;
        rau_pkg::rsp_t o;
        ln = r.lhs_num; ld = r.lhs_den; rn = r.rhs_num; rd = r.rhs_den;
        ls = r.lhs_neg; rs = r.rhs_neg; ovf = 0;
        if (rau_pkg::op_t'(r.operation) == rau_pkg::OP_SUB)
            rs = !rs;
        if (rau_pkg::op_t'(r.operation) == rau_pkg::OP_DIV)
        begin
            tmp = rn; rn = rd; rd = tmp;
        end
        if (rau_pkg::op_t'(r.operation) == rau_pkg::OP_ADD ||
            rau_pkg::op_t'(r.operation) == rau_pkg::OP_SUB)
        begin
            t1 = wrap_mul(ln, rd, ovf);
            t2 = wrap_mul(ld, rn, ovf);
            den = wrap_mul(ld, rd, ovf);
            if (ls == rs)
            begin
                sum = {1'b0, t1} + {1'b0, t2};
                if (sum[WB])
                    ovf = 1;
                num = sum[WB-1:0];
                neg = ls;
            end
            else if (t1 > t2)
            begin
                num = t1 - t2;
                neg = ls;
            end
            else
            begin
                num = t2 - t1;
                neg = (t2 > t1) ? rs : 1'b0;
            end
        end
        else
        begin
            num = wrap_mul(ln, rn, ovf);
            den = wrap_mul(ld, rd, ovf);
            neg = ls ^ rs;
        end
        x = num; y = den;
        while (y != 0)
        begin
            tmp = x % y; x = y; y = tmp;
        end
        if (x > 1)
        begin
            num = num / x;
            den = den / x;
        end
        if (num == 0)
            neg = 0;
        o.res_num = num; o.res_den = den; o.res_neg = neg; o.overflow = ovf;
        return o;
    endfunction

    // Drives one item and waits for its acceptance; random gap first if gaps.
    // busy is read at the falling edge, so it is the value the next rising
    // edge sees.
    task automatic send_item(rau_pkg::req_t r, bit gaps);
        if (gaps)
            while ($urandom_range(99) < 17)
            begin
                start <= 1'b0;
                @(posedge clk);
            end
        start <= 1'b1;
        req <= r;
        @(negedge clk);
        while (busy)
            @(negedge clk);
        @(posedge clk);
        sb.note_item(reduced_fraction(r));
    endtask

    // Mostly small operands so the Euclid loop stays short; some full-width.
    function automatic logic [63:0] rand_field();
        case ($urandom_range(5))
            0: return {$urandom, $urandom};
            1: return 64'($urandom_range(3));
            2: return ~64'($urandom_range(3));
            default: return 64'($urandom_range(1000));
        endcase
    endfunction

    function automatic rau_pkg::req_t rand_item();
        rau_pkg::req_t r;
        r.operation = 2'($urandom_range(3));
        r.lhs_num = rand_field(); r.lhs_den = rand_field();
        r.rhs_num = rand_field(); r.rhs_den = rand_field();
        r.lhs_neg = 1'($urandom); r.rhs_neg = 1'($urandom);
        return r;
    endfunction

    function automatic rau_pkg::req_t mk(rau_pkg::op_t op, logic [63:0] a,
                                         logic [63:0] b, bit an,
                                         logic [63:0] c, logic [63:0] d, bit cn);
        rau_pkg::req_t r;
        r.operation = op; r.lhs_num = a; r.lhs_den = b; r.lhs_neg = an;
        r.rhs_num = c; r.rhs_den = d; r.rhs_neg = cn;
        return r;
    endfunction

    // Results are sampled at the edge that ends their strobe cycle.
    always @(posedge clk)
        if (rst_n && done)
            sb.check_result(rsp);

    // Watchdog: cycles with no acceptance of either side.
    always @(posedge clk)
    begin
        if ((start && !busy) || done || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            timed_out = 1'b1;
            $display("tb_top failed");
            $finish;
        end
    end

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // directed: each op, extremes, equal cross terms, zero num/den, 0/0
        send_item(mk(rau_pkg::OP_ADD, 1, 2, 0, 1, 3, 0), 0);
        send_item(mk(rau_pkg::OP_SUB, 1, 2, 0, 1, 2, 0), 0);     // equal: zero, positive
        send_item(mk(rau_pkg::OP_SUB, 1, 3, 0, 1, 2, 0), 0);     // larger right term
        send_item(mk(rau_pkg::OP_ADD, 5, 4, 1, 1, 4, 0), 0);     // larger left negative
        send_item(mk(rau_pkg::OP_MUL, 2, 3, 1, 3, 4, 0), 0);
        send_item(mk(rau_pkg::OP_DIV, 2, 3, 1, 4, 9, 1), 0);
        send_item(mk(rau_pkg::OP_MUL, 0, 7, 1, 5, 3, 0), 0);     // zero numerator
        send_item(mk(rau_pkg::OP_MUL, 6, 0, 0, 4, 1, 0), 0);     // zero denominator
        send_item(mk(rau_pkg::OP_MUL, 0, 0, 0, 0, 0, 1), 0);     // 0/0
        send_item(mk(rau_pkg::OP_ADD, '1, '1, 1, '1, '1, 1), 0); // all ones: wraps
        send_item(mk(rau_pkg::OP_SUB, '1, 1, 0, '1, 1, 1), 0);   // sum wraps
        send_item(mk(rau_pkg::OP_MUL, '1, 1, 0, 2, 1, 0), 0);
        send_item(mk(rau_pkg::OP_DIV, 64'h8000_0000_0000_0000, 3, 0, 0, 5, 0), 0);
        send_item(mk(rau_pkg::OP_ADD, 0, 1, 1, 0, 1, 1), 0);
        send_item(mk(rau_pkg::OP_DIV, 1, 1, 0, 1, 1, 0), 0);
        // random with gaps, and a stretch without in the middle
        for (int i = 0; i < 600; i++)
            send_item(rand_item(), !(i >= 250 && i < 350));
        start <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (sb.errors == 0 && !timed_out)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end
endmodule
